// File: hdl/qbd_pkg.sv
// shared constants and types for the quadrature boxcar demodulator
`timescale 1ns / 1ps

package qbd_pkg;

	localparam int CHANNELS   = 4;
	localparam int RING_DEPTH = 16;
	localparam int SUM_SHIFT  = 4;

	localparam int SAMPLE_W = 24;
	localparam int PROD_W   = 25;
	localparam int PHASE_W  = 4;
	localparam int STEP_W   = 8;
	localparam int CHAN_W   = 2;

	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RAW_SUM_W  = SAMPLE_W + RING_AW + 1;
	localparam int PROD_SUM_W = PROD_W + RING_AW + 1;
	localparam int ENTRY_W    = SAMPLE_W + 2 * PROD_W;
	localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [RING_AW-1:0] LAST_POS    = RING_AW'(RING_DEPTH - 1);
	localparam logic [CH_AW-1:0]   LAST_CH     = CH_AW'(CHANNELS - 1);
	localparam logic [PHASE_W-1:0] QUAD_OFFSET = PHASE_W'(4);
	localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(1);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] raw;
		logic signed [PROD_W-1:0]   inph;
		logic signed [PROD_W-1:0]   quad;
	} avg_t;

	typedef struct packed {
		logic               accept;
		logic               neg_i;
		logic               neg_q;
		logic [RING_AW-1:0] rd_addr;
		logic               advance;
		logic [RING_AW-1:0] wr_addr;
		logic               old_ok;
	} lane_ctrl_t;

endpackage

// File: hdl/qbd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module qbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/qbd_lane.sv
// one channel lane: sign products, ring storage and running window sums
`timescale 1ns / 1ps

module qbd_lane import qbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctrl_t          ctrl,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                sample_ok,
	output avg_t                avg
);

	logic signed [SAMPLE_W-1:0]   x;
	logic signed [PROD_W-1:0]     xi;
	logic signed [PROD_W-1:0]     xq;
	logic signed [SAMPLE_W-1:0]   x_s1;
	logic signed [PROD_W-1:0]     xi_s1;
	logic signed [PROD_W-1:0]     xq_s1;
	logic [ENTRY_W-1:0]           rdata;
	logic [ENTRY_W-1:0]           old;
	logic signed [SAMPLE_W-1:0]   old_x;
	logic signed [PROD_W-1:0]     old_xi;
	logic signed [PROD_W-1:0]     old_xq;
	logic signed [RAW_SUM_W-1:0]  raw_sum_q;
	logic signed [PROD_SUM_W-1:0] inph_sum_q;
	logic signed [PROD_SUM_W-1:0] quad_sum_q;
	logic signed [RAW_SUM_W-1:0]  raw_sum_d;
	logic signed [PROD_SUM_W-1:0] inph_sum_d;
	logic signed [PROD_SUM_W-1:0] quad_sum_d;
	logic signed [RAW_SUM_W-1:0]  raw_sh;
	logic signed [PROD_SUM_W-1:0] inph_sh;
	logic signed [PROD_SUM_W-1:0] quad_sh;

	// invalid sample counts as zero
	always_comb begin
		x  = sample_ok ? signed'(sample) : '0;
		xi = ctrl.neg_i ? -PROD_W'(x) : PROD_W'(x);
		xq = ctrl.neg_q ? -PROD_W'(x) : PROD_W'(x);
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			x_s1  <= x;
			xi_s1 <= xi;
			xq_s1 <= xq;
		end
	end

	qbd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ctrl.advance),
		.waddr (ctrl.wr_addr),
		.wdata ({x_s1, xi_s1, xq_s1}),
		.re    (ctrl.accept),
		.raddr (ctrl.rd_addr),
		.rdata (rdata)
	);

	// entries not yet written since reset read as zero
	always_comb begin
		old    = ctrl.old_ok ? rdata : '0;
		old_x  = signed'(old[ENTRY_W-1 -: SAMPLE_W]);
		old_xi = signed'(old[2*PROD_W-1 -: PROD_W]);
		old_xq = signed'(old[PROD_W-1:0]);

		raw_sum_d  = raw_sum_q + RAW_SUM_W'(x_s1) - RAW_SUM_W'(old_x);
		inph_sum_d = inph_sum_q + PROD_SUM_W'(xi_s1) - PROD_SUM_W'(old_xi);
		quad_sum_d = quad_sum_q + PROD_SUM_W'(xq_s1) - PROD_SUM_W'(old_xq);

		raw_sh  = raw_sum_d >>> SUM_SHIFT;
		inph_sh = inph_sum_d >>> SUM_SHIFT;
		quad_sh = quad_sum_d >>> SUM_SHIFT;

		avg.raw  = signed'(raw_sh[SAMPLE_W-1:0]);
		avg.inph = signed'(inph_sh[PROD_W-1:0]);
		avg.quad = signed'(quad_sh[PROD_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_sum_q  <= '0;
			inph_sum_q <= '0;
			quad_sum_q <= '0;
		end else if (ctrl.advance) begin
			raw_sum_q  <= raw_sum_d;
			inph_sum_q <= inph_sum_d;
			quad_sum_q <= quad_sum_d;
		end
	end

endmodule

// File: hdl/qbd_merge.sv
// result buffer that serialises the lane results one channel per transaction
`timescale 1ns / 1ps

module qbd_merge import qbd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  avg_t                      lanes [CHANNELS],
	input  logic [PHASE_W-1:0]        phase,
	output logic                      ready,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CHAN_W-1:0]         channel,
	output logic signed [SAMPLE_W-1:0] avg_raw,
	output logic signed [PROD_W-1:0]  avg_inphase,
	output logic signed [PROD_W-1:0]  avg_quadrature,
	output logic [PHASE_W-1:0]        phase_now,
	output logic                      last
);

	avg_t               buf_q [CHANNELS];
	logic [PHASE_W-1:0] phase_q;
	logic               valid_q;
	logic [CH_AW-1:0]   cnt_q;
	logic               at_last;
	logic               take;

	always_comb begin
		at_last = (cnt_q == LAST_CH);
		take    = valid_q && !out_stall;
		// buffer frees when its final transaction goes out
		ready   = !valid_q || (take && at_last);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q   <= lanes;
			phase_q <= phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (take) begin
			if (at_last) begin
				valid_q <= 1'b0;
				cnt_q   <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		out_valid      = valid_q;
		channel        = CHAN_W'(cnt_q);
		avg_raw        = buf_q[cnt_q].raw;
		avg_inphase    = buf_q[cnt_q].inph;
		avg_quadrature = buf_q[cnt_q].quad;
		phase_now      = phase_q;
		last           = at_last;
	end

endmodule

// File: hdl/quadrature_boxcar_demodulator.sv
// top level: phase and ring position control, channel lanes and result merge
// an accepted item waits in the stage one registers until the result buffer is free,
// then the buffer shows its channel 0 result first; the single result port carries
// one channel per transaction, and the next item is taken while one waits
// reset clears the window sums, ring entry valid bits, phase and position, step is 1
`timescale 1ns / 1ps

module quadrature_boxcar_demodulator import qbd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [STEP_W-1:0]          cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        sample_0,
	input  logic [SAMPLE_W-1:0]        sample_1,
	input  logic [SAMPLE_W-1:0]        sample_2,
	input  logic [SAMPLE_W-1:0]        sample_3,
	input  logic                       valid_0,
	input  logic                       valid_1,
	input  logic                       valid_2,
	input  logic                       valid_3,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [CHAN_W-1:0]          channel,
	output logic signed [SAMPLE_W-1:0] avg_raw,
	output logic signed [PROD_W-1:0]   avg_inphase,
	output logic signed [PROD_W-1:0]   avg_quadrature,
	output logic [PHASE_W-1:0]         phase_now,
	output logic                       last
);

	logic [STEP_W-1:0]   step_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [PHASE_W-1:0]  next_phase;
	logic [PHASE_W-1:0]  quad_phase;
	logic [RING_AW-1:0]  pos_q;
	logic                ring_ok_q [RING_DEPTH];
	logic                s1_valid_q;
	logic [RING_AW-1:0]  pos_s1;
	logic                old_ok_s1;
	logic [PHASE_W-1:0]  phase_s1;
	logic                accept;
	logic                advance;
	logic                merge_ready;
	lane_ctrl_t          ctrl;
	logic [SAMPLE_W-1:0] samples [4];
	logic                oks [4];
	avg_t                lane_avg [CHANNELS];

	always_comb begin
		samples = '{sample_0, sample_1, sample_2, sample_3};
		oks     = '{valid_0, valid_1, valid_2, valid_3};
	end

	always_comb begin
		in_stall   = s1_valid_q && !merge_ready;
		accept     = in_valid && !in_stall;
		advance    = s1_valid_q && merge_ready;
		next_phase = phase_q + step_q[PHASE_W-1:0];
		quad_phase = phase_q + QUAD_OFFSET;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= (cfg_wdata == '0) ? STEP_RESET : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= next_phase;
			pos_q   <= (pos_q == LAST_POS) ? '0 : pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1    <= pos_q;
			old_ok_s1 <= ring_ok_q[pos_q];
			phase_s1  <= next_phase;
		end
	end

	// one valid bit per ring row, shared by all lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_ok_q[i] <= 1'b0;
			end
		end else if (advance) begin
			ring_ok_q[pos_s1] <= 1'b1;
		end
	end

	always_comb begin
		ctrl.accept  = accept;
		ctrl.neg_i   = phase_q[PHASE_W-1];
		ctrl.neg_q   = quad_phase[PHASE_W-1];
		ctrl.rd_addr = pos_q;
		ctrl.advance = advance;
		ctrl.wr_addr = pos_s1;
		ctrl.old_ok  = old_ok_s1;
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		qbd_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.sample    (samples[c]),
			.sample_ok (oks[c]),
			.avg       (lane_avg[c])
		);
	end

	qbd_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance),
		.lanes          (lane_avg),
		.phase          (phase_s1),
		.ready          (merge_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.channel        (channel),
		.avg_raw        (avg_raw),
		.avg_inphase    (avg_inphase),
		.avg_quadrature (avg_quadrature),
		.phase_now      (phase_now),
		.last           (last)
	);

endmodule

// File: hdl/qbd_checker.sv
// port level checks on the result sequence, bound to the top level
`timescale 1ns / 1ps

module qbd_props import qbd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAN_W-1:0] channel,
	input logic              last
);

	// stalled result keeps its channel
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(channel))
		else $error("stalled result changed");

	// results of one item follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside an item's results");

	a_chan_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> channel == $past(channel) + 1'b1)
		else $error("channel order broken");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (channel == CHAN_W'(CHANNELS - 1))))
		else $error("last flag on wrong channel");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> channel == '0)
		else $error("next item does not start at channel zero");

endmodule

bind quadrature_boxcar_demodulator qbd_props u_qbd_props (.*);

// File: sim/qbd_checker.sv
// checker for the quadrature boxcar demodulator: window predictor and result scoreboard
`timescale 1ns / 1ps

module qbd_checker import qbd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [STEP_W-1:0]          cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        sample_0,
	input  logic [SAMPLE_W-1:0]        sample_1,
	input  logic [SAMPLE_W-1:0]        sample_2,
	input  logic [SAMPLE_W-1:0]        sample_3,
	input  logic                       valid_0,
	input  logic                       valid_1,
	input  logic                       valid_2,
	input  logic                       valid_3,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [CHAN_W-1:0]          channel,
	input  logic signed [SAMPLE_W-1:0] avg_raw,
	input  logic signed [PROD_W-1:0]   avg_inphase,
	input  logic signed [PROD_W-1:0]   avg_quadrature,
	input  logic [PHASE_W-1:0]         phase_now,
	input  logic                       last,
	output int                         fail_count,
	output int                         pending,
	output int                         checked
);

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] raw;
		logic signed [PROD_W-1:0]   inph;
		logic signed [PROD_W-1:0]   quad;
		logic [PHASE_W-1:0]         phase;
		logic                       lst;
	} demod_result_t;

	demod_result_t want_q[$];

	// window history and running sums per channel
	logic signed [SAMPLE_W-1:0] raw_hist  [CHANNELS][RING_DEPTH];
	logic signed [PROD_W-1:0]   inph_hist [CHANNELS][RING_DEPTH];
	logic signed [PROD_W-1:0]   quad_hist [CHANNELS][RING_DEPTH];
	longint                     raw_acc   [CHANNELS];
	longint                     inph_acc  [CHANNELS];
	longint                     quad_acc  [CHANNELS];
	int                         slot;
	logic [PHASE_W-1:0]         phase_cnt;
	logic [STEP_W-1:0]          step_reg;

	task automatic predict_demod;
		logic [SAMPLE_W-1:0] smp [4];
		logic                vld [4];
		logic                neg_i;
		logic                neg_q;
		logic [PHASE_W-1:0]  qph;
		logic [PHASE_W-1:0]  nxt;
		longint              x;
		longint              xi;
		longint              xq;
		longint              shifted;
		demod_result_t       r;
		smp[0] = sample_0; smp[1] = sample_1; smp[2] = sample_2; smp[3] = sample_3;
		vld[0] = valid_0;  vld[1] = valid_1;  vld[2] = valid_2;  vld[3] = valid_3;
		neg_i = phase_cnt[PHASE_W-1];
		qph   = phase_cnt + QUAD_OFFSET;
		neg_q = qph[PHASE_W-1];
		nxt   = phase_cnt + step_reg[PHASE_W-1:0];
		for (int ch = 0; ch < CHANNELS; ch++) begin
			x  = vld[ch] ? longint'($signed(smp[ch])) : 64'sd0;
			xi = neg_i ? -x : x;
			xq = neg_q ? -x : x;
			raw_acc[ch]  += x  - longint'(raw_hist[ch][slot]);
			inph_acc[ch] += xi - longint'(inph_hist[ch][slot]);
			quad_acc[ch] += xq - longint'(quad_hist[ch][slot]);
			raw_hist[ch][slot]  = x[SAMPLE_W-1:0];
			inph_hist[ch][slot] = xi[PROD_W-1:0];
			quad_hist[ch][slot] = xq[PROD_W-1:0];
			r.chan  = CHAN_W'(ch);
			shifted = raw_acc[ch] >>> SUM_SHIFT;
			r.raw   = shifted[SAMPLE_W-1:0];
			shifted = inph_acc[ch] >>> SUM_SHIFT;
			r.inph  = shifted[PROD_W-1:0];
			shifted = quad_acc[ch] >>> SUM_SHIFT;
			r.quad  = shifted[PROD_W-1:0];
			r.phase = nxt;
			r.lst   = (ch == CHANNELS - 1);
			want_q.push_back(r);
		end
		slot = (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
		phase_cnt = nxt;
	endtask

	task automatic check_demod;
		demod_result_t w;
		if (want_q.size() == 0) begin
			$error("result on channel %0d with no transaction outstanding", channel);
			fail_count++;
		end else begin
			w = want_q.pop_front();
			checked++;
			if (channel !== w.chan) begin
				$error("channel mismatch: expected %0d, actual %0d", w.chan, channel);
				fail_count++;
			end
			if (avg_raw !== w.raw) begin
				$error("avg_raw mismatch: expected %0d, actual %0d", w.raw, avg_raw);
				fail_count++;
			end
			if (avg_inphase !== w.inph) begin
				$error("avg_inphase mismatch: expected %0d, actual %0d", w.inph, avg_inphase);
				fail_count++;
			end
			if (avg_quadrature !== w.quad) begin
				$error("avg_quadrature mismatch: expected %0d, actual %0d",
					w.quad, avg_quadrature);
				fail_count++;
			end
			if (phase_now !== w.phase) begin
				$error("phase_now mismatch: expected %0d, actual %0d", w.phase, phase_now);
				fail_count++;
			end
			if (last !== w.lst) begin
				$error("last mismatch: expected %0d, actual %0d", w.lst, last);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int p = 0; p < RING_DEPTH; p++) begin
					raw_hist[c][p]  = '0;
					inph_hist[c][p] = '0;
					quad_hist[c][p] = '0;
				end
				raw_acc[c]  = 0;
				inph_acc[c] = 0;
				quad_acc[c] = 0;
			end
			want_q.delete();
			slot       = 0;
			phase_cnt  = '0;
			step_reg   = STEP_RESET;
			fail_count = 0;
			pending    = 0;
			checked    = 0;
		end else begin
			if (out_valid && !out_stall)
				check_demod();
			if (cfg_we)
				step_reg = (cfg_wdata == '0) ? STEP_RESET : cfg_wdata;
			if (in_valid && !in_stall)
				predict_demod();
			pending = want_q.size();
		end
	end

endmodule

// File: sim/tb.sv
// testbench top: stimulus, idling, phase step settings and verdict
`timescale 1ns / 1ps

module tb;
	import qbd_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 70;

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [STEP_W-1:0]          cfg_wdata = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic [SAMPLE_W-1:0]        sample_0  = '0;
	logic [SAMPLE_W-1:0]        sample_1  = '0;
	logic [SAMPLE_W-1:0]        sample_2  = '0;
	logic [SAMPLE_W-1:0]        sample_3  = '0;
	logic                       valid_0   = 1'b0;
	logic                       valid_1   = 1'b0;
	logic                       valid_2   = 1'b0;
	logic                       valid_3   = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [CHAN_W-1:0]          channel;
	logic signed [SAMPLE_W-1:0] avg_raw;
	logic signed [PROD_W-1:0]   avg_inphase;
	logic signed [PROD_W-1:0]   avg_quadrature;
	logic [PHASE_W-1:0]         phase_now;
	logic                       last;
	int                         fail_count;
	int                         pending;
	int                         checked;

	int cycle_count = 0;
	int items_sent  = 0;
	bit tx_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;

	logic [STEP_W-1:0] step_plan [6] = '{8'd1, 8'd255, 8'd0, 8'd16, 8'd7, 8'd0};

	quadrature_boxcar_demodulator dut (.*);

	qbd_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		out_stall <= rx_idle_on && ($urandom_range(0, 99) < 19);

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
			input logic [SAMPLE_W-1:0] s2, input logic [SAMPLE_W-1:0] s3,
			input logic [3:0] v);
		if (tx_idle_on && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		sample_0 <= s0;
		sample_1 <= s1;
		sample_2 <= s2;
		sample_3 <= s3;
		{valid_3, valid_2, valid_1, valid_0} <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain_results;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_step(input logic [STEP_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 24'h800000;
			1:       return 24'h7FFFFF;
			2:       return 24'hFFFFFF;
			3:       return 24'h000000;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_valids();
		logic [3:0] v;
		for (int i = 0; i < 4; i++)
			v[i] = ($urandom_range(0, 99) < 80);
		return v;
	endfunction

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// a zero step must behave as a step of one
		write_step(8'd0);
		// most negative value through every phase fills the window at both sign extremes
		for (int i = 0; i < RING_DEPTH; i++)
			send_item(24'h800000, 24'h800000, 24'h800000, 24'h800000, 4'hF);
		send_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 4'hF);
		send_item(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001, 4'hF);
		send_item(24'h000000, 24'h000000, 24'h000000, 24'h000000, 4'hF);
		send_item(24'hABCDEF, 24'h543210, 24'hFFFFFF, 24'h800000, 4'h0);
		send_item(24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 4'b1010);
		drain_results();
		write_step(8'd255);
		send_item(24'h123456, 24'hEDCBA9, 24'h800000, 24'h7FFFFF, 4'b0101);
		send_item(24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFE, 4'hF);
		drain_results();
		// step of sixteen leaves the phase where it is
		write_step(8'd16);
		send_item(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 4'hF);
		send_item(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hF0F0F0, 4'hF);

		for (int ph = 0; ph < 6; ph++) begin
			drain_results();
			write_step((ph == 5) ? STEP_W'($urandom) : step_plan[ph]);
			tx_idle_on = (ph != 3);
			rx_idle_on = (ph != 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 1 && i == PHASE_ITEMS / 2)
					drain_results();
				send_item(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
					pick_valids());
			end
		end

		drain_results();
		$display("checked %0d channel results from %0d sample sets", checked, items_sent);
		$display("phase steps 0, 1, 7, 16, 255 and a random one, with and without idling");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/qbd_pkg.sv
hdl/qbd_ram.sv
hdl/qbd_lane.sv
hdl/qbd_merge.sv
hdl/quadrature_boxcar_demodulator.sv
hdl/qbd_checker.sv
sim/qbd_checker.sv
sim/tb.sv
